### rtl/core/i2cras_pkg.sv
// Package for the I2C register access sequencer: item/result structs,
// operation and bus action codes, and step numbers. No dependencies.
`default_nettype none

package i2cras_pkg;

  typedef enum logic [1:0] {
    OP_START_READ  = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_BYTE_DONE   = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_START_SEND  = 3'd0,
    ACT_SEND        = 3'd1,
    ACT_STOP        = 3'd2,
    ACT_RSTART_SEND = 3'd3,
    ACT_RX_NACK     = 3'd4,
    ACT_STOP_CAP    = 3'd5,
    ACT_RELEASE     = 3'd6,
    ACT_NONE        = 3'd7
  } action_t;

  localparam logic [2:0] STEP_REG  = 3'd0;
  localparam logic [2:0] STEP_ONE  = 3'd1;
  localparam logic [2:0] STEP_TWO  = 3'd2;
  localparam logic [2:0] STEP_THREE = 3'd3;
  localparam logic [2:0] STEP_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] received_byte;
    logic [7:0] write_data;
    logic [7:0] register_address;
    logic [6:0] slave_address;
    logic [1:0] operation;
  } item_t;

  typedef struct packed {
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic [7:0] bus_byte;
    logic [2:0] bus_action;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/i2cras_seq.sv
// Transaction state and step decision of the I2C register access sequencer.
// Depends on i2cras_pkg.
`default_nettype none

module i2cras_seq (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    en,
  input  i2cras_pkg::item_t      item,
  output i2cras_pkg::result_t    result
);

  logic [2:0] step_count, step_count_next;
  logic       write_mode, write_mode_next;
  logic       in_progress, in_progress_next;
  logic [6:0] target_address, target_address_next;
  logic [7:0] target_register, target_register_next;
  logic [7:0] pending_data, pending_data_next;

  always_comb begin
    step_count_next      = step_count;
    write_mode_next      = write_mode;
    in_progress_next     = in_progress;
    target_address_next  = target_address;
    target_register_next = target_register;
    pending_data_next    = pending_data;
    result.bus_action    = i2cras_pkg::ACT_NONE;
    result.bus_byte      = 8'd0;
    result.read_data     = 8'd0;
    result.read_valid    = 1'b0;

    unique case (i2cras_pkg::op_t'(item.operation)) inside
      i2cras_pkg::OP_START_READ, i2cras_pkg::OP_START_WRITE: begin
        // Restart unconditionally, even mid-transaction.
        target_address_next  = item.slave_address;
        target_register_next = item.register_address;
        if (item.operation == i2cras_pkg::OP_START_WRITE) begin
          pending_data_next = item.write_data;
        end
        write_mode_next   = (item.operation == i2cras_pkg::OP_START_WRITE);
        in_progress_next  = 1'b1;
        step_count_next   = i2cras_pkg::STEP_REG;
        result.bus_action = i2cras_pkg::ACT_START_SEND;
        result.bus_byte   = {item.slave_address, 1'b0};
      end
      i2cras_pkg::OP_BYTE_DONE: begin
        if (step_count == i2cras_pkg::STEP_REG) begin
          result.bus_action = i2cras_pkg::ACT_SEND;
          result.bus_byte   = target_register;
          step_count_next   = i2cras_pkg::STEP_ONE;
        end else if (write_mode && step_count == i2cras_pkg::STEP_ONE) begin
          result.bus_action = i2cras_pkg::ACT_SEND;
          result.bus_byte   = pending_data;
          step_count_next   = i2cras_pkg::STEP_TWO;
        end else if (write_mode && step_count == i2cras_pkg::STEP_TWO) begin
          result.bus_action = i2cras_pkg::ACT_STOP;
          in_progress_next  = 1'b0;
          step_count_next   = i2cras_pkg::STEP_THREE;
        end else if (!write_mode && step_count == i2cras_pkg::STEP_ONE) begin
          result.bus_action = i2cras_pkg::ACT_RSTART_SEND;
          result.bus_byte   = {target_address, 1'b1};
          step_count_next   = i2cras_pkg::STEP_TWO;
        end else if (!write_mode && step_count == i2cras_pkg::STEP_TWO) begin
          result.bus_action = i2cras_pkg::ACT_RX_NACK;
          step_count_next   = i2cras_pkg::STEP_THREE;
        end else if (!write_mode && step_count == i2cras_pkg::STEP_THREE) begin
          result.bus_action = i2cras_pkg::ACT_STOP_CAP;
          result.read_data  = item.received_byte;
          result.read_valid = 1'b1;
          in_progress_next  = 1'b0;
          step_count_next   = i2cras_pkg::STEP_FOUR;
        end else begin
          // Past the last step: release the bus, hold the state.
          result.bus_action = i2cras_pkg::ACT_RELEASE;
        end
      end
      default: begin
        // Unused code: no action, state holds.
        result.bus_action = i2cras_pkg::ACT_NONE;
      end
    endcase

    result.busy_res = in_progress_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count      <= 3'd0;
      write_mode      <= 1'b0;
      in_progress     <= 1'b0;
      target_address  <= 7'd0;
      target_register <= 8'd0;
      pending_data    <= 8'd0;
    end else if (en) begin
      step_count      <= step_count_next;
      write_mode      <= write_mode_next;
      in_progress     <= in_progress_next;
      target_address  <= target_address_next;
      target_register <= target_register_next;
      pending_data    <= pending_data_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/i2c_register_access_sequencer.sv
// An accepted item passes the input register, then the result register, before m_tvalid.
// Throughput: one item per cycle; the input register and the result register each
// advance whenever the result register is empty or its item is being taken.
// Reset (rst, synchronous, active high) empties both registers and clears the
// transaction state (step count, mode, busy, latched addresses and data) to zero.
// Depends on i2cras_pkg and i2cras_seq.
`default_nettype none

module i2c_register_access_sequencer (
  input  wire         clk,
  input  wire         rst,
  // Slave side: one controller event per item.
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // slave_address[6:0], register_address[14:7],
                                 // write_data[22:15], received_byte[30:23], zero pad
  input  wire  [1:0]  s_tuser,   // operation[1:0]
  // Master side: one bus order per item.
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata    // bus_action[2:0], bus_byte[10:3], read_data[18:11],
                                 // read_valid[19], busy_res[20], zero pad
);

  // Input register: holds one accepted item until the sequencer takes it.
  logic                s1_valid;
  i2cras_pkg::item_t   s1_item;
  logic                s1_adv;
  i2cras_pkg::result_t seq_result;
  i2cras_pkg::result_t out_result;

  // Advance the input register whenever the result register frees up
  // in this cycle; accept a new item whenever the input register drains.
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_item.operation        <= s_tuser;
      s1_item.slave_address    <= s_tdata[6:0];
      s1_item.register_address <= s_tdata[14:7];
      s1_item.write_data       <= s_tdata[22:15];
      s1_item.received_byte    <= s_tdata[30:23];
    end
  end

  // Step decision; state updates only when the item moves on.
  i2cras_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_adv),
    .item   (s1_item),
    .result (seq_result)
  );

  // Result register: drop valid once taken, load on each advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result <= seq_result;
    end
  end

  assign m_tdata = {3'd0, out_result.busy_res, out_result.read_valid,
                    out_result.read_data, out_result.bus_byte, out_result.bus_action};

endmodule

`default_nettype wire

### rtl/core/i2cras_checker.sv
// Port-level checks for the I2C register access sequencer, bound to the top level.
// Depends on i2cras_pkg and i2c_register_access_sequencer.
`default_nettype none

module i2cras_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata
);

  // Result stays put while stalled.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A captured byte only comes with stop+capture, which ends the transaction.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |->
      m_tdata[2:0] == i2cras_pkg::ACT_STOP_CAP && !m_tdata[20])
    else $error("read_valid without stop+capture");

  // A start sets busy and addresses the slave in write direction.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == i2cras_pkg::ACT_START_SEND |->
      m_tdata[20] && !m_tdata[3])
    else $error("start without busy or with read bit");

  // Release and no-op orders carry no byte and no capture.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == i2cras_pkg::ACT_RELEASE ||
                 m_tdata[2:0] == i2cras_pkg::ACT_NONE) |->
      m_tdata[10:3] == 8'd0 && !m_tdata[19])
    else $error("release or none carries data");

  // Nothing is offered in the first cycle out of reset.
  assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind i2c_register_access_sequencer i2cras_checker u_i2cras_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
